FILE: rtl/core/buddy_page_allocator_defines.svh
// Assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// check outside reset
`define BPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check at every edge, reset included
`define BPA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bpa_pkg.sv
package bpa_pkg;

	localparam int PAGE_COUNT = 1024;
	localparam int TOP_ORDER  = 10;
	localparam int IDX_W      = $clog2(PAGE_COUNT);
	localparam int LNK_W      = IDX_W + 1;
	localparam int ORD_W      = $clog2(TOP_ORDER + 1);
	localparam int HEAD_N     = TOP_ORDER + 1;

	localparam logic [LNK_W-1:0] NIL = LNK_W'(PAGE_COUNT);

	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_DONATE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OOM      = 2'd1;
	localparam logic [1:0] ST_NOT_USED = 2'd2;
	localparam logic [1:0] ST_PERM     = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_K0,
		OP_KINC,
		OP_HEAD_TO_P,
		OP_X_P,
		OP_X_B,
		OP_U_RD,
		OP_U_LINK,
		OP_U_NIL,
		OP_P_LINK,
		OP_P_BACK,
		OP_SPLIT_B,
		OP_CHK_RD,
		OP_REL_START,
		OP_BUD_CALC,
		OP_BUD_RD,
		OP_MERGE,
		OP_ORD_P,
		OP_SET_USED,
		OP_RES_OOM,
		OP_RES_NU,
		OP_RES_PERM,
		OP_RES_OK,
		OP_PUBLISH
	} op_t;

	typedef struct packed {
		logic       clr_done;
		logic       head_valid;
		logic       k_top;
		logic       k_zero;
		logic       pg_valid;
		logic       b_valid;
		logic       in_use;
		logic       perm;
		logic       bud_free;
		logic [1:0] req;
	} stat_t;

	function automatic logic pg_ok(input logic [LNK_W-1:0] x);
		return x < NIL;
	endfunction

endpackage

FILE: rtl/core/bpa_ctrl.sv
module bpa_ctrl import bpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output op_t   op
);

	localparam logic [4:0] S_CLR     = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_DISP    = 5'd2;
	localparam logic [4:0] S_A_SCAN  = 5'd3;
	localparam logic [4:0] S_A_HEAD  = 5'd4;
	localparam logic [4:0] S_A_LAST  = 5'd5;
	localparam logic [4:0] S_A_SPLIT = 5'd6;
	localparam logic [4:0] S_A_PB    = 5'd7;
	localparam logic [4:0] S_A_PP    = 5'd8;
	localparam logic [4:0] S_A_NEXT  = 5'd9;
	localparam logic [4:0] S_A_USE   = 5'd10;
	localparam logic [4:0] S_CHK     = 5'd11;
	localparam logic [4:0] S_R_LOOP  = 5'd12;
	localparam logic [4:0] S_R_BV    = 5'd13;
	localparam logic [4:0] S_R_BCHK  = 5'd14;
	localparam logic [4:0] S_R_MERGE = 5'd15;
	localparam logic [4:0] S_R_ORD   = 5'd16;
	localparam logic [4:0] S_U_RD    = 5'd17;
	localparam logic [4:0] S_U_LINK  = 5'd18;
	localparam logic [4:0] S_U_NIL   = 5'd19;
	localparam logic [4:0] S_P_LINK  = 5'd20;
	localparam logic [4:0] S_P_BACK  = 5'd21;
	localparam logic [4:0] S_FIN     = 5'd22;

	logic [4:0] state_q, state_d, ret_q, ret_d;
	logic       out_valid_q, pub;

	always_comb begin
		op      = OP_NONE;
		state_d = state_q;
		ret_d   = ret_q;
		pub     = 1'b0;
		unique case (state_q)
			S_CLR: begin
				op = OP_CLR;
				if (stat.clr_done) begin
					op      = OP_NONE;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.req == REQ_ALLOC) begin
					op      = OP_K0;
					state_d = S_A_SCAN;
				end else if (stat.req == REQ_FREE || stat.req == REQ_DONATE) begin
					if (!stat.pg_valid) begin
						op      = OP_RES_NU;
						state_d = S_FIN;
					end else begin
						op      = OP_CHK_RD;
						state_d = S_CHK;
					end
				end else begin
					op      = OP_RES_OK;
					state_d = S_FIN;
				end
			end
			S_A_SCAN: begin
				if (stat.head_valid) begin
					state_d = stat.k_zero ? S_A_LAST : S_A_HEAD;
				end else if (stat.k_top) begin
					op      = OP_RES_OOM;
					state_d = S_FIN;
				end else begin
					op = OP_KINC;
				end
			end
			S_A_HEAD: begin
				op      = OP_HEAD_TO_P;
				ret_d   = S_A_SPLIT;
				state_d = S_U_RD;
			end
			S_A_LAST: begin
				op      = OP_HEAD_TO_P;
				ret_d   = S_A_USE;
				state_d = S_U_RD;
			end
			S_A_SPLIT: begin
				op      = OP_SPLIT_B;
				state_d = S_A_PB;
			end
			S_A_PB: begin
				if (stat.b_valid) begin
					op      = OP_X_B;
					ret_d   = S_A_PP;
					state_d = S_P_LINK;
				end else begin
					state_d = S_A_PP;
				end
			end
			S_A_PP: begin
				op      = OP_X_P;
				ret_d   = S_A_NEXT;
				state_d = S_P_LINK;
			end
			S_A_NEXT: begin
				state_d = stat.k_zero ? S_A_LAST : S_A_HEAD;
			end
			S_A_USE: begin
				op      = OP_SET_USED;
				state_d = S_FIN;
			end
			S_CHK: begin
				if (!stat.in_use) begin
					op      = OP_RES_NU;
					state_d = S_FIN;
				end else if (stat.perm && stat.req != REQ_DONATE) begin
					op      = OP_RES_PERM;
					state_d = S_FIN;
				end else begin
					op      = OP_REL_START;
					state_d = S_R_LOOP;
				end
			end
			S_R_LOOP: begin
				if (stat.k_top) begin
					op      = OP_X_P;
					ret_d   = S_FIN;
					state_d = S_P_LINK;
				end else begin
					op      = OP_BUD_CALC;
					state_d = S_R_BV;
				end
			end
			S_R_BV: begin
				if (!stat.b_valid) begin
					op      = OP_X_P;
					ret_d   = S_FIN;
					state_d = S_P_LINK;
				end else begin
					op      = OP_BUD_RD;
					state_d = S_R_BCHK;
				end
			end
			S_R_BCHK: begin
				if (!stat.bud_free) begin
					op      = OP_X_P;
					ret_d   = S_FIN;
					state_d = S_P_LINK;
				end else begin
					op      = OP_X_B;
					ret_d   = S_R_MERGE;
					state_d = S_U_RD;
				end
			end
			S_R_MERGE: begin
				op      = OP_MERGE;
				state_d = S_R_ORD;
			end
			S_R_ORD: begin
				op      = OP_ORD_P;
				state_d = S_R_LOOP;
			end
			S_U_RD: begin
				op      = OP_U_RD;
				state_d = S_U_LINK;
			end
			S_U_LINK: begin
				op      = OP_U_LINK;
				state_d = S_U_NIL;
			end
			S_U_NIL: begin
				op      = OP_U_NIL;
				state_d = ret_q;
			end
			S_P_LINK: begin
				op      = OP_P_LINK;
				state_d = S_P_BACK;
			end
			S_P_BACK: begin
				op      = OP_P_BACK;
				state_d = ret_q;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					op      = OP_PUBLISH;
					pub     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ret_q       <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (pub)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/bpa_dpath.sv
module bpa_dpath import bpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  op_t              op,
	input  logic [1:0]       req_type,
	input  logic [9:0]       page_num,
	output stat_t            stat,
	output logic [9:0]       page_num_out,
	output logic [1:0]       status
);

	logic             in_use_mem [PAGE_COUNT];
	logic             perm_mem   [PAGE_COUNT];
	logic [ORD_W-1:0] ord_mem    [PAGE_COUNT];
	logic [LNK_W-1:0] fwd_mem    [PAGE_COUNT];
	logic [LNK_W-1:0] bwd_mem    [PAGE_COUNT];

	logic             in_use_rd, perm_rd;
	logic [ORD_W-1:0] ord_rd;
	logic [LNK_W-1:0] fwd_rd, bwd_rd;

	logic [LNK_W-1:0] head_q [HEAD_N];
	logic [IDX_W:0]   clr_q;

	logic [1:0]       req_q, st_q;
	logic [LNK_W-1:0] pg_q, p_q, b_q, x_q, f_q;
	logic [ORD_W-1:0] k_q;
	logic [IDX_W-1:0] res_q;
	logic [LNK_W-1:0] head_k;

	logic             rd_en;
	logic [IDX_W-1:0] raddr;
	logic             iu_we, iu_wd, pm_we, pm_wd, od_we, fw_we, bw_we, hd_we;
	logic [IDX_W-1:0] iu_wa, pm_wa, od_wa, fw_wa, bw_wa;
	logic [ORD_W-1:0] od_wd;
	logic [LNK_W-1:0] fw_wd, bw_wd, hd_wd;
	logic [IDX_W-1:0] clr_a;

	assign head_k = head_q[k_q];
	assign clr_a  = clr_q[IDX_W-1:0];

	always_comb begin
		rd_en = 1'b0;
		raddr = x_q[IDX_W-1:0];
		iu_we = 1'b0; iu_wa = clr_a; iu_wd = 1'b1;
		pm_we = 1'b0; pm_wa = clr_a; pm_wd = 1'b1;
		od_we = 1'b0; od_wa = clr_a; od_wd = '0;
		fw_we = 1'b0; fw_wa = clr_a; fw_wd = NIL;
		bw_we = 1'b0; bw_wa = clr_a; bw_wd = NIL;
		hd_we = 1'b0; hd_wd = NIL;
		unique case (op)
			OP_CLR: begin
				iu_we = 1'b1;
				pm_we = 1'b1;
				od_we = 1'b1;
				fw_we = 1'b1;
				bw_we = 1'b1;
			end
			OP_CHK_RD: begin
				rd_en = 1'b1;
				raddr = pg_q[IDX_W-1:0];
			end
			OP_U_RD: rd_en = 1'b1;
			OP_BUD_RD: begin
				rd_en = 1'b1;
				raddr = b_q[IDX_W-1:0];
			end
			OP_U_LINK: begin
				if (pg_ok(bwd_rd)) begin
					fw_we = 1'b1;
					fw_wa = bwd_rd[IDX_W-1:0];
					fw_wd = fwd_rd;
				end else begin
					hd_we = 1'b1;
					hd_wd = fwd_rd;
				end
				if (pg_ok(fwd_rd)) begin
					bw_we = 1'b1;
					bw_wa = fwd_rd[IDX_W-1:0];
					bw_wd = bwd_rd;
				end
			end
			OP_U_NIL: begin
				fw_we = 1'b1;
				fw_wa = x_q[IDX_W-1:0];
				bw_we = 1'b1;
				bw_wa = x_q[IDX_W-1:0];
			end
			OP_P_LINK: begin
				fw_we = 1'b1;
				fw_wa = x_q[IDX_W-1:0];
				fw_wd = head_k;
				bw_we = 1'b1;
				bw_wa = x_q[IDX_W-1:0];
				od_we = 1'b1;
				od_wa = x_q[IDX_W-1:0];
				od_wd = k_q;
				hd_we = 1'b1;
				hd_wd = x_q;
			end
			OP_P_BACK: begin
				if (pg_ok(f_q)) begin
					bw_we = 1'b1;
					bw_wa = f_q[IDX_W-1:0];
					bw_wd = x_q;
				end
			end
			OP_REL_START: begin
				iu_we = 1'b1;
				iu_wa = pg_q[IDX_W-1:0];
				iu_wd = 1'b0;
				od_we = 1'b1;
				od_wa = pg_q[IDX_W-1:0];
				pm_we = (req_q == REQ_DONATE);
				pm_wa = pg_q[IDX_W-1:0];
				pm_wd = 1'b0;
			end
			OP_ORD_P: begin
				od_we = 1'b1;
				od_wa = p_q[IDX_W-1:0];
				od_wd = k_q;
			end
			OP_SET_USED: begin
				iu_we = 1'b1;
				iu_wa = x_q[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (iu_we) in_use_mem[iu_wa] <= iu_wd;
		if (pm_we) perm_mem[pm_wa]   <= pm_wd;
		if (od_we) ord_mem[od_wa]    <= od_wd;
		if (fw_we) fwd_mem[fw_wa]    <= fw_wd;
		if (bw_we) bwd_mem[bw_wa]    <= bw_wd;
		if (rd_en) begin
			in_use_rd <= in_use_mem[raddr];
			perm_rd   <= perm_mem[raddr];
			ord_rd    <= ord_mem[raddr];
			fwd_rd    <= fwd_mem[raddr];
			bwd_rd    <= bwd_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			for (int i = 0; i < HEAD_N; i++)
				head_q[i] <= NIL;
		end else begin
			if (op == OP_CLR)
				clr_q <= clr_q + 1'b1;
			if (hd_we)
				head_q[k_q] <= hd_wd;
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				req_q <= req_type;
				pg_q  <= LNK_W'(page_num);
			end
			OP_K0:        k_q <= '0;
			OP_KINC:      k_q <= k_q + 1'b1;
			OP_HEAD_TO_P: begin
				p_q <= head_k;
				x_q <= head_k;
			end
			OP_X_P:       x_q <= p_q;
			OP_X_B:       x_q <= b_q;
			OP_P_LINK:    f_q <= head_k;
			OP_SPLIT_B: begin
				b_q <= p_q ^ (LNK_W'(1) << (k_q - 1'b1));
				k_q <= k_q - 1'b1;
			end
			OP_REL_START: begin
				p_q   <= pg_q;
				k_q   <= '0;
				res_q <= pg_q[IDX_W-1:0];
				st_q  <= ST_OK;
			end
			OP_BUD_CALC:  b_q <= p_q ^ (LNK_W'(1) << k_q);
			OP_MERGE: begin
				p_q <= p_q & ~((LNK_W'(2) << k_q) - LNK_W'(1));
				k_q <= k_q + 1'b1;
			end
			OP_SET_USED: begin
				res_q <= x_q[IDX_W-1:0];
				st_q  <= ST_OK;
			end
			OP_RES_OOM: begin
				res_q <= '0;
				st_q  <= ST_OOM;
			end
			OP_RES_NU: begin
				res_q <= pg_q[IDX_W-1:0];
				st_q  <= ST_NOT_USED;
			end
			OP_RES_PERM: begin
				res_q <= pg_q[IDX_W-1:0];
				st_q  <= ST_PERM;
			end
			OP_RES_OK: begin
				res_q <= pg_q[IDX_W-1:0];
				st_q  <= ST_OK;
			end
			OP_PUBLISH: begin
				page_num_out <= 10'(res_q);
				status       <= st_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.clr_done   = (clr_q == (IDX_W + 1)'(PAGE_COUNT));
		stat.head_valid = pg_ok(head_k);
		stat.k_top      = (k_q == ORD_W'(TOP_ORDER));
		stat.k_zero     = (k_q == '0);
		stat.pg_valid   = pg_ok(pg_q);
		stat.b_valid    = pg_ok(b_q);
		stat.in_use     = in_use_rd;
		stat.perm       = perm_rd;
		stat.bud_free   = !in_use_rd && (ord_rd == k_q);
		stat.req        = req_q;
	end

endmodule

FILE: rtl/core/buddy_page_allocator.sv
// Result time, accept to result valid, grows with each order split for allocate and with each merge
// for free/donate; out of memory ends after the order scan, rejected free/donate and reserved requests skip the lists.
// Throughput: one item in flight; the next is accepted once the result is registered,
// and a full result register holds the controller. One read port and the list updates set this.
// Reset: asynchronous; a clearing pass over the page tables holds the input off until it is done.
module buddy_page_allocator import bpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [9:0] page_num,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [9:0] page_num_out,
	output logic [1:0] status
);

	stat_t stat;
	op_t   op;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.op        (op)
	);

	bpa_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.req_type     (req_type),
		.page_num     (page_num),
		.stat         (stat),
		.page_num_out (page_num_out),
		.status       (status)
	);

endmodule

FILE: rtl/core/bpa_checker.sv
`include "buddy_page_allocator_defines.svh"

module bpa_checker import bpa_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [9:0] page_num_out,
	input logic [1:0] status
);

	`BPA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(page_num_out) && $stable(status), "result changed while stalled")
	`BPA_ASSERT(a_oom_zero, out_valid && status == ST_OOM |-> page_num_out == 10'd0, "out of memory with nonzero page")
	`BPA_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")
	`BPA_ASSERT_ALWAYS(a_reset, !arst_n |-> !out_valid && !in_ready, "handshake active in reset")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.page_num_out (page_num_out),
	.status       (status)
);
